@@ design/mme_pkg.sv @@
// Package: constants, codes, types and helpers for the matrix multiply engine.
`default_nettype none
package mme_pkg;

    localparam int MAX_DIM     = 8;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int ELEM_W   = 16;
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int SUM_W    = 40;
    localparam int OPC_W    = 2;
    localparam int INDEX_W  = 6;
    localparam int POS_W    = 3;
    localparam int CFG_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic [OPC_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OPC_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OPC_W-1:0] OP_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

    typedef enum logic [1:0]
    {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_DRAIN
    } seq_state_t;

    // tag that travels with one multiply term down the datapath
    typedef struct packed
    {
        logic             valid;
        logic             first;
        logic             last_term;
        logic             last_elem;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } term_tag_t;

    // dimension register to last index, 0 taken as 1, above MAX_DIM taken as MAX_DIM
    function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_W-1:0] d);
        logic [CFG_W-1:0] dm1;
        dm1 = d - 4'd1;
        if (d == '0)
            return '0;
        else if (int'(d) > MAX_DIM)
            return DIM_W'(MAX_DIM - 1);
        else
            return DIM_W'(dm1);
    endfunction

endpackage
`default_nettype wire

@@ design/mme_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ design/mme_seq.sv @@
// Sequencer: walks row, column and inner index, issues one term per cycle.
`default_nettype none
module mme_seq import mme_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start_compute,
    input  wire logic [DIM_W-1:0] rows_last,
    input  wire logic [DIM_W-1:0] inner_last,
    input  wire logic [DIM_W-1:0] cols_last,
    input  wire logic             final_load,
    output logic                  busy,
    output logic [ADDR_W-1:0]     a_addr,
    output logic [ADDR_W-1:0]     b_addr,
    output term_tag_t             tag
);

    seq_state_t state_reg, state_next;

    logic [DIM_W-1:0]  r_reg, r_next;
    logic [DIM_W-1:0]  c_reg, c_next;
    logic [DIM_W-1:0]  n_reg, n_next;
    logic [ADDR_W-1:0] a_base_reg, a_base_next;
    logic [ADDR_W-1:0] b_idx_reg, b_idx_next;

    logic [ADDR_W-1:0] inner_len;
    logic [ADDR_W-1:0] cols_len;
    logic              n_end;
    logic              c_end;
    logic              r_end;
    logic              issue;

    assign inner_len = ADDR_W'(inner_last) + ADDR_W'(1);
    assign cols_len  = ADDR_W'(cols_last) + ADDR_W'(1);
    assign n_end     = (n_reg == inner_last);
    assign c_end     = (c_reg == cols_last);
    assign r_end     = (r_reg == rows_last);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (start_compute)
                    state_next = SEQ_RUN;
            end
            SEQ_RUN:
            begin
                if (n_end && c_end && r_end)
                    state_next = SEQ_DRAIN;
            end
            SEQ_DRAIN:
            begin
                if (final_load)
                    state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        issue = 1'b0;
        busy  = 1'b1;
        case (state_reg)
            SEQ_IDLE:
            begin
                busy = 1'b0;
            end
            SEQ_RUN:
            begin
                issue = 1'b1;
            end
            SEQ_DRAIN:
            begin
                issue = 1'b0;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        r_next      = r_reg;
        c_next      = c_reg;
        n_next      = n_reg;
        a_base_next = a_base_reg;
        b_idx_next  = b_idx_reg;
        if (start_compute && state_reg == SEQ_IDLE)
        begin
            r_next      = '0;
            c_next      = '0;
            n_next      = '0;
            a_base_next = '0;
            b_idx_next  = '0;
        end
        else if (issue)
        begin
            if (!n_end)
            begin
                n_next     = n_reg + DIM_W'(1);
                b_idx_next = b_idx_reg + cols_len;
            end
            else
            begin
                n_next = '0;
                if (!c_end)
                begin
                    c_next     = c_reg + DIM_W'(1);
                    b_idx_next = ADDR_W'(c_reg) + ADDR_W'(1);
                end
                else
                begin
                    c_next     = '0;
                    b_idx_next = '0;
                    if (!r_end)
                    begin
                        r_next      = r_reg + DIM_W'(1);
                        a_base_next = a_base_reg + inner_len;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_IDLE;
            r_reg      <= '0;
            c_reg      <= '0;
            n_reg      <= '0;
            a_base_reg <= '0;
            b_idx_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            r_reg      <= r_next;
            c_reg      <= c_next;
            n_reg      <= n_next;
            a_base_reg <= a_base_next;
            b_idx_reg  <= b_idx_next;
        end
    end

    assign a_addr = a_base_reg + ADDR_W'(n_reg);
    assign b_addr = b_idx_reg;

    always_comb
    begin
        tag.valid     = issue;
        tag.first     = (n_reg == '0);
        tag.last_term = n_end;
        tag.last_elem = c_end && r_end;
        tag.row       = r_reg;
        tag.col       = c_reg;
    end

endmodule
`default_nettype wire

@@ design/mme_mac.sv @@
// Shared multiply-accumulate unit with result register.
`default_nettype none
module mme_mac import mme_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire term_tag_t         tag_in,
    input  wire logic [ELEM_W-1:0] a_data,
    input  wire logic [ELEM_W-1:0] b_data,
    output logic                   final_load,
    output logic                   result_valid,
    output logic [POS_W-1:0]       out_row,
    output logic [POS_W-1:0]       out_col,
    output logic [SUM_W-1:0]       product_value,
    output logic                   last_element
);

    term_tag_t                tag1_reg;
    term_tag_t                tag2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic        [SUM_W-1:0]  acc_reg;
    logic        [SUM_W-1:0]  sum_next;
    logic        [SUM_W-1:0]  prod_ext;
    logic                     res_valid_reg;
    logic        [POS_W-1:0]  row_reg;
    logic        [POS_W-1:0]  col_reg;
    logic        [SUM_W-1:0]  value_reg;
    logic                     last_reg;
    logic                     emit;

    assign prod_ext = {{(SUM_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign sum_next = (tag2_reg.first ? '0 : acc_reg) + prod_ext;
    assign emit     = tag2_reg.valid && tag2_reg.last_term;
    assign final_load = emit && tag2_reg.last_elem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg      <= '0;
            tag2_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            tag1_reg      <= tag_in;
            tag2_reg      <= tag1_reg;
            res_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(a_data) * $signed(b_data);
        if (tag2_reg.valid)
        begin
            acc_reg <= sum_next;
        end
        if (emit)
        begin
            row_reg   <= POS_W'(tag2_reg.row);
            col_reg   <= POS_W'(tag2_reg.col);
            value_reg <= sum_next;
            last_reg  <= tag2_reg.last_elem;
        end
    end

    assign result_valid  = res_valid_reg;
    assign out_row       = row_reg;
    assign out_col       = col_reg;
    assign product_value = value_reg;
    assign last_element  = last_reg;

endmodule
`default_nettype wire

@@ design/matrix_multiply_engine.sv @@
// Top level: config registers, A and B element stores, sequencer and MAC.
// Load item: written at the accepting edge, busy stays low, next item may follow at once.
// Compute item: busy until the final sum is loaded, one term per cycle through one multiplier.
// Each result passes the store read register, the product register and the result register to the ports.
// Results are single-cycle strobes; the receiver cannot stall.
// Reset: config registers to 8, sequencer idle; element stores keep no reset value.
`default_nettype none
module matrix_multiply_engine import mme_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [OPC_W-1:0]     opcode,
    input  wire logic [INDEX_W-1:0]   flat_index,
    input  wire logic signed [ELEM_W-1:0] element_value,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output logic                      result_valid,
    output logic [POS_W-1:0]          out_row,
    output logic [POS_W-1:0]          out_col,
    output logic signed [SUM_W-1:0]   product_value,
    output logic                      last_element
);

    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] inner_reg;
    logic [CFG_W-1:0] cols_reg;

    logic              accept;
    logic              in_range;
    logic              we_a;
    logic              we_b;
    logic              start_compute;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic [ELEM_W-1:0] a_data;
    logic [ELEM_W-1:0] b_data;
    logic              final_load;
    logic [SUM_W-1:0]  sum_out;
    term_tag_t         tag;

    assign cfg_ready     = !busy;
    assign accept        = start && !busy;
    assign in_range      = (int'(flat_index) < STORE_DEPTH);
    assign waddr         = ADDR_W'(flat_index);
    assign we_a          = accept && in_range && (opcode == OP_WRITE_A);
    assign we_b          = accept && in_range && (opcode == OP_WRITE_B);
    assign start_compute = accept && (opcode == OP_COMPUTE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= CFG_RESET;
            inner_reg <= CFG_RESET;
            cols_reg  <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROWS:  rows_reg  <= cfg_data;
                CFG_INNER: inner_reg <= cfg_data;
                CFG_COLS:  cols_reg  <= cfg_data;
                default:   rows_reg  <= rows_reg;
            endcase
        end
    end

    mme_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (element_value),
        .raddr (a_addr),
        .rdata (a_data)
    );

    mme_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (element_value),
        .raddr (b_addr),
        .rdata (b_data)
    );

    mme_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start_compute (start_compute),
        .rows_last     (dim_last(rows_reg)),
        .inner_last    (dim_last(inner_reg)),
        .cols_last     (dim_last(cols_reg)),
        .final_load    (final_load),
        .busy          (busy),
        .a_addr        (a_addr),
        .b_addr        (b_addr),
        .tag           (tag)
    );

    mme_mac u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .tag_in        (tag),
        .a_data        (a_data),
        .b_data        (b_data),
        .final_load    (final_load),
        .result_valid  (result_valid),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (sum_out),
        .last_element  (last_element)
    );

    assign product_value = sum_out;

endmodule
`default_nettype wire

@@ design/mme_checker.sv @@
// Port-level checker for the matrix multiply engine, bound to the top level.
`default_nettype none
module mme_checker import mme_pkg::*; (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic [OPC_W-1:0]     opcode,
    input wire logic                 result_valid,
    input wire logic                 last_element
);

    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode != OP_COMPUTE |=> !busy)
        else $error("load item made the engine busy");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == OP_COMPUTE |=> busy)
        else $error("compute item did not make the engine busy");

    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy || $past(busy))
        else $error("result outside a compute item");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_element |-> !busy)
        else $error("engine still busy after final element");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_element |-> busy)
        else $error("engine idle before final element");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);
`default_nettype wire
